FILE: src/capc_pkg.sv
package capc_pkg;

  localparam int SIG_FRAC   = 4;
  localparam int INTEG_FRAC = 8;
  localparam int GAIN_FRAC  = 8;
  localparam int FINE_BITS  = SIG_FRAC + 2 * GAIN_FRAC;
  localparam int INC_SHIFT  = FINE_BITS - INTEG_FRAC;
  localparam int OUT_SHIFT  = FINE_BITS;

  localparam int SIG_W   = 16;
  localparam int GAIN_W  = 12;
  localparam int THR_W   = 12;
  localparam int ALT_W   = 12;
  localparam int RLIM_W  = 11;
  localparam int INTEG_W = 18;
  localparam int INTEG_MAX = 2 ** (INTEG_W - 1) - 1;

  localparam int A_W     = SIG_W + 1;
  localparam int E_W     = A_W + GAIN_W + 2;
  localparam int P_W     = E_W + GAIN_W + 1;
  localparam int ACC_W   = P_W + 2;
  localparam int CLAMP_W = 24;
  localparam int ILIM_W  = 25;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_SCALE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LIMIT    = 3'd6;

  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_PREP = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

  typedef enum logic [3:0] {
    OP_PREP,
    OP_MUL_T,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_I,
    OP_INC,
    OP_CLAMP,
    OP_TOTAL,
    OP_OUT
  } op_e;

  typedef enum logic {
    J_NEXT,
    J_AXIS_LOOP
  } jmp_e;

  typedef struct packed {
    op_e               op;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic       en;
    op_e        op;
    logic [1:0] axis;
  } ctl_t;

  typedef struct packed {
    logic signed [SIG_W-1:0] ref_roll;
    logic signed [SIG_W-1:0] ref_pitch;
    logic signed [SIG_W-1:0] ref_yaw;
    logic signed [SIG_W-1:0] angle_roll;
    logic signed [SIG_W-1:0] angle_pitch;
    logic signed [SIG_W-1:0] rate_roll;
    logic signed [SIG_W-1:0] rate_pitch;
    logic signed [SIG_W-1:0] rate_yaw;
    logic [THR_W-1:0]        throttle;
  } sample_t;

  typedef struct packed {
    logic [GAIN_W-1:0] outer_gain;
    logic [GAIN_W-1:0] inner_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] integ_limit;
    logic [THR_W-1:0]  throttle_min;
    logic [GAIN_W-1:0] yaw_scale;
    logic [RLIM_W-1:0] ref_limit;
  } cfg_t;

  // per-axis microprogram, looped three times
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{op: OP_OUT, jmp: J_NEXT, target: STEP_PREP};
    unique case (step)
      4'd0:    w.op = OP_PREP;
      4'd1:    w.op = OP_MUL_T;
      4'd2:    w.op = OP_ERR;
      4'd3:    w.op = OP_MUL_P;
      4'd4:    w.op = OP_MUL_I;
      4'd5:    w.op = OP_INC;
      4'd6:    w.op = OP_CLAMP;
      4'd7:    w.op = OP_TOTAL;
      4'd8:    w = '{op: OP_OUT, jmp: J_AXIS_LOOP, target: STEP_PREP};
      default: w = '{op: OP_OUT, jmp: J_AXIS_LOOP, target: STEP_PREP};
    endcase
    return w;
  endfunction

endpackage

FILE: src/cascaded_attitude_pi_controller_top.sv
// Cascaded P/PI attitude and rate controller, one control tick per beat.
// Input channel (in_valid_i / in_stall_o) carries references, measured angles
// and rates and throttle; output channel (out_valid_o / out_stall_i) carries
// the three axis drives and the altitude copy. A beat moves on a rising edge
// with valid high and stall low.
// Configuration writes (cfg_valid_i / cfg_ready_o, index and data) are taken
// at any time; write them only while no tick is in flight.
// A microcoded sequencer runs a nine-step program per axis over one shared
// multiplier, three passes per tick: the result is registered when the yaw
// pass ends, and no new beat is taken while a tick is running. The input side
// takes the next beat while the previous result waits; if that result is
// still held when the next one finishes, the sequencer waits on its last step.
// Reset clears the integrators, loads default gains and limits and drops both
// valid and busy.
module cascaded_attitude_pi_controller_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [capc_pkg::SIG_W-1:0]      ref_roll_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      ref_pitch_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      ref_yaw_i,
  input  logic [capc_pkg::ALT_W-1:0]             ref_alt_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      angle_roll_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      angle_pitch_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      rate_roll_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      rate_pitch_i,
  input  logic signed [capc_pkg::SIG_W-1:0]      rate_yaw_i,
  input  logic [capc_pkg::THR_W-1:0]             throttle_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [capc_pkg::SIG_W-1:0]      drive_roll_o,
  output logic signed [capc_pkg::SIG_W-1:0]      drive_pitch_o,
  output logic signed [capc_pkg::SIG_W-1:0]      drive_yaw_o,
  output logic [capc_pkg::ALT_W-1:0]             drive_alt_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [capc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [capc_pkg::GAIN_W-1:0]            cfg_data_i
);

  localparam int STEP_W = capc_pkg::STEP_W;

  logic                          busy_q;
  logic [STEP_W-1:0]             step_q;
  logic [1:0]                    axis_q;
  logic                          out_valid_q;
  capc_pkg::cfg_t                cfg_q;
  capc_pkg::sample_t             smp_q;
  logic [capc_pkg::ALT_W-1:0]    alt_q;
  logic signed [capc_pkg::SIG_W-1:0] drv_roll_q, drv_pitch_q, drv_yaw_q;
  logic [capc_pkg::ALT_W-1:0]    drv_alt_q;

  capc_pkg::ucw_t                uw;
  capc_pkg::ctl_t                ctl;
  logic                          in_acc, loop_step, last_axis, finish;
  logic signed [capc_pkg::SIG_W-1:0] dp_roll, dp_pitch, dp_sat;

  assign uw        = capc_pkg::ucode(step_q);
  assign in_acc    = in_valid_i && !busy_q;
  assign loop_step = busy_q && (uw.jmp == capc_pkg::J_AXIS_LOOP);
  assign last_axis = (axis_q == capc_pkg::AXIS_YAW);
  assign finish    = loop_step && last_axis && (!out_valid_q || !out_stall_i);

  assign ctl = '{en: busy_q, op: uw.op, axis: axis_q};

  capc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .smp_i         (smp_q),
    .cfg_i         (cfg_q),
    .drive_roll_o  (dp_roll),
    .drive_pitch_o (dp_pitch),
    .sat_o         (dp_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= capc_pkg::STEP_PREP;
      axis_q      <= capc_pkg::AXIS_ROLL;
      out_valid_q <= 1'b0;
      cfg_q       <= '{outer_gain: 12'd512, inner_gain: 12'd256, integ_gain: 12'd307,
                       integ_limit: 12'd500, throttle_min: 12'd100, yaw_scale: 12'd1024,
                       ref_limit: 11'd50};
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          capc_pkg::REG_OUTER_GAIN:   cfg_q.outer_gain   <= cfg_data_i;
          capc_pkg::REG_INNER_GAIN:   cfg_q.inner_gain   <= cfg_data_i;
          capc_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i;
          capc_pkg::REG_INTEG_LIMIT:  cfg_q.integ_limit  <= cfg_data_i;
          capc_pkg::REG_THROTTLE_MIN: cfg_q.throttle_min <= cfg_data_i;
          capc_pkg::REG_YAW_SCALE:    cfg_q.yaw_scale    <= cfg_data_i;
          capc_pkg::REG_REF_LIMIT:    cfg_q.ref_limit    <= cfg_data_i[capc_pkg::RLIM_W-1:0];
          default: ;
        endcase
      end

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        busy_q <= 1'b1;
        step_q <= capc_pkg::STEP_PREP;
        axis_q <= capc_pkg::AXIS_ROLL;
      end else if (busy_q) begin
        if (uw.jmp == capc_pkg::J_NEXT) begin
          step_q <= step_q + STEP_W'(1);
        end else if (!last_axis) begin
          axis_q <= axis_q + 2'd1;
          step_q <= uw.target;
        end else if (finish) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= '{ref_roll: ref_roll_i, ref_pitch: ref_pitch_i, ref_yaw: ref_yaw_i,
                 angle_roll: angle_roll_i, angle_pitch: angle_pitch_i,
                 rate_roll: rate_roll_i, rate_pitch: rate_pitch_i, rate_yaw: rate_yaw_i,
                 throttle: throttle_i};
      alt_q <= ref_alt_i;
    end
    if (finish) begin
      drv_roll_q  <= dp_roll;
      drv_pitch_q <= dp_pitch;
      drv_yaw_q   <= dp_sat;
      drv_alt_q   <= alt_q;
    end
  end

  assign in_stall_o    = busy_q;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign drive_roll_o  = drv_roll_q;
  assign drive_pitch_o = drv_pitch_q;
  assign drive_yaw_o   = drv_yaw_q;
  assign drive_alt_o   = drv_alt_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer not busy after input beat");

  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= capc_pkg::STEP_LAST) && (axis_q <= capc_pkg::AXIS_YAW))
    else $error("step or axis counter out of range");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q) && !busy_q)
    else $error("result raised without a finished program");
`endif

endmodule

FILE: src/capc_datapath.sv
module capc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  capc_pkg::ctl_t                       ctl_i,
  input  capc_pkg::sample_t                    smp_i,
  input  capc_pkg::cfg_t                       cfg_i,
  output logic signed [capc_pkg::SIG_W-1:0]    drive_roll_o,
  output logic signed [capc_pkg::SIG_W-1:0]    drive_pitch_o,
  output logic signed [capc_pkg::SIG_W-1:0]    sat_o
);

  localparam int A_W     = capc_pkg::A_W;
  localparam int E_W     = capc_pkg::E_W;
  localparam int P_W     = capc_pkg::P_W;
  localparam int ACC_W   = capc_pkg::ACC_W;
  localparam int CLAMP_W = capc_pkg::CLAMP_W;
  localparam int ILIM_W  = capc_pkg::ILIM_W;
  localparam int SIG_W   = capc_pkg::SIG_W;
  localparam int INTEG_W = capc_pkg::INTEG_W;
  localparam int GAIN_W  = capc_pkg::GAIN_W;

  localparam logic [ACC_W-1:0] INC_BIAS =
    ACC_W'((64'd1 << capc_pkg::INC_SHIFT) - 64'd1);
  localparam logic [ACC_W-1:0] OUT_BIAS =
    ACC_W'((64'd1 << capc_pkg::OUT_SHIFT) - 64'd1);
  localparam logic [ILIM_W-1:0] ILIM_MAX = ILIM_W'(capc_pkg::INTEG_MAX);
  localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] DRV_MIN = ACC_W'(-32768);

  logic signed [A_W-1:0]     a_q;
  logic signed [E_W-1:0]     e_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [ACC_W-1:0]   m_q;
  logic signed [ACC_W-1:0]   s_q;
  logic signed [INTEG_W-1:0] integ_q [3];
  logic signed [SIG_W-1:0]   w_q [2];

  logic signed [SIG_W-1:0]   ref_sel, ang_sel, rate_sel;
  logic signed [INTEG_W-1:0] integ_sel;
  logic signed [CLAMP_W-1:0] rlim, ref_w, ref_c;
  logic signed [A_W-1:0]     prep;
  logic signed [E_W-1:0]     mul_a, err;
  logic signed [GAIN_W:0]    mul_b;
  logic signed [P_W-1:0]     prod;
  logic signed [ACC_W-1:0]   inc_rnd, inc, s_d, total, out_rnd, out_tr;
  logic [ILIM_W-1:0]         ilim_raw, ilim;
  logic signed [ACC_W-1:0]   ilim_s, s_clamped;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      is_yaw;

  assign is_yaw = (ctl_i.axis == capc_pkg::AXIS_YAW);

  always_comb begin
    unique case (ctl_i.axis)
      capc_pkg::AXIS_ROLL: begin
        ref_sel   = smp_i.ref_roll;
        ang_sel   = smp_i.angle_roll;
        rate_sel  = smp_i.rate_roll;
        integ_sel = integ_q[0];
      end
      capc_pkg::AXIS_PITCH: begin
        ref_sel   = smp_i.ref_pitch;
        ang_sel   = smp_i.angle_pitch;
        rate_sel  = smp_i.rate_pitch;
        integ_sel = integ_q[1];
      end
      default: begin
        ref_sel   = smp_i.ref_yaw;
        ang_sel   = '0;
        rate_sel  = smp_i.rate_yaw;
        integ_sel = integ_q[2];
      end
    endcase
  end

  // reference clamp and angle error for roll and pitch; yaw takes its raw reference
  assign rlim  = signed'(CLAMP_W'(cfg_i.ref_limit) << capc_pkg::SIG_FRAC);
  assign ref_w = CLAMP_W'(ref_sel);
  assign ref_c = (ref_w > rlim) ? rlim : ((ref_w < -rlim) ? -rlim : ref_w);
  assign prep  = is_yaw ? A_W'(ref_sel) : (A_W'(ref_c) - A_W'(ang_sel));

  // shared multiplier
  always_comb begin
    mul_a = e_q;
    mul_b = signed'({1'b0, cfg_i.inner_gain});
    case (ctl_i.op)
      capc_pkg::OP_MUL_T: begin
        mul_a = E_W'(a_q);
        mul_b = is_yaw ? signed'({1'b0, cfg_i.yaw_scale}) : signed'({1'b0, cfg_i.outer_gain});
      end
      capc_pkg::OP_MUL_I: mul_b = signed'({1'b0, cfg_i.integ_gain});
      default: ;
    endcase
  end
  assign prod = P_W'(mul_a) * P_W'(mul_b);

  assign err = E_W'(m_q) - (E_W'(rate_sel) <<< capc_pkg::GAIN_FRAC);

  // increment truncated toward zero
  assign inc_rnd = m_q + signed'(m_q[ACC_W-1] ? INC_BIAS : '0);
  assign inc     = inc_rnd >>> capc_pkg::INC_SHIFT;
  assign s_d     = ACC_W'(integ_sel) + inc;

  assign ilim_raw  = ILIM_W'(cfg_i.integ_limit) << capc_pkg::INTEG_FRAC;
  assign ilim      = (ilim_raw > ILIM_MAX) ? ILIM_MAX : ilim_raw;
  assign ilim_s    = signed'(ACC_W'(ilim));
  assign s_clamped = (s_q > ilim_s) ? ilim_s : ((s_q < -ilim_s) ? -ilim_s : s_q);
  assign integ_new = (smp_i.throttle < cfg_i.throttle_min) ? '0 : INTEG_W'(s_clamped);

  assign total = ACC_W'(p_q) + (ACC_W'(integ_sel) <<< capc_pkg::INC_SHIFT);

  assign out_rnd = m_q + signed'(m_q[ACC_W-1] ? OUT_BIAS : '0);
  assign out_tr  = out_rnd >>> capc_pkg::OUT_SHIFT;
  assign sat_o   = (out_tr > DRV_MAX) ? SIG_W'(DRV_MAX) :
                   ((out_tr < DRV_MIN) ? SIG_W'(DRV_MIN) : SIG_W'(out_tr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      integ_q[2] <= '0;
    end else if (ctl_i.en && ctl_i.op == capc_pkg::OP_CLAMP) begin
      case (ctl_i.axis)
        capc_pkg::AXIS_ROLL:  integ_q[0] <= integ_new;
        capc_pkg::AXIS_PITCH: integ_q[1] <= integ_new;
        capc_pkg::AXIS_YAW:   integ_q[2] <= integ_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      unique case (ctl_i.op)
        capc_pkg::OP_PREP:  a_q <= prep;
        capc_pkg::OP_MUL_T: m_q <= ACC_W'(prod);
        capc_pkg::OP_ERR:   e_q <= err;
        capc_pkg::OP_MUL_P: p_q <= prod;
        capc_pkg::OP_MUL_I: m_q <= ACC_W'(prod);
        capc_pkg::OP_INC:   s_q <= s_d;
        capc_pkg::OP_TOTAL: m_q <= total;
        capc_pkg::OP_OUT: begin
          if (!is_yaw) w_q[ctl_i.axis[0]] <= sat_o;
        end
        default: ;
      endcase
    end
  end

  assign drive_roll_o  = w_q[0];
  assign drive_pitch_o = w_q[1];

endmodule

FILE: tb/attitude_drive_checker.sv
module attitude_drive_checker
  import capc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  sample_t                 sample_i,
  input  logic [ALT_W-1:0]        alt_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [SIG_W-1:0] drive_roll_i,
  input  logic signed [SIG_W-1:0] drive_pitch_i,
  input  logic signed [SIG_W-1:0] drive_yaw_i,
  input  logic [ALT_W-1:0]        drive_alt_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [GAIN_W-1:0]       cfg_data_i,
  output int unsigned             fail_cnt_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic signed [SIG_W-1:0] roll;
    logic signed [SIG_W-1:0] pitch;
    logic signed [SIG_W-1:0] yaw;
    logic [ALT_W-1:0]        alt;
  } drives_t;

  cfg_t    gains;
  longint  integ[3];
  drives_t expected_drives[$];

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one control tick: angle P loop on roll and pitch, scaled reference on yaw, then PI rate loop on each axis
  function automatic drives_t predict_drives(input sample_t s, input logic [ALT_W-1:0] a);
    longint  refs[3];
    longint  ang[2];
    longint  rates[3];
    longint  rlim, ilim, target, err, acc, total;
    drives_t d;
    int      ax;
    refs[0]  = s.ref_roll;
    refs[1]  = s.ref_pitch;
    refs[2]  = s.ref_yaw;
    ang[0]   = s.angle_roll;
    ang[1]   = s.angle_pitch;
    rates[0] = s.rate_roll;
    rates[1] = s.rate_pitch;
    rates[2] = s.rate_yaw;
    rlim = longint'(gains.ref_limit) <<< SIG_FRAC;
    ilim = longint'(gains.integ_limit) <<< INTEG_FRAC;
    if (ilim > INTEG_MAX) ilim = INTEG_MAX;
    d = '0;
    for (ax = 0; ax < 3; ax++) begin
      if (ax == AXIS_YAW) begin
        target = longint'(gains.yaw_scale) * refs[2];
      end else begin
        target = longint'(gains.outer_gain) * (clip(refs[ax], -rlim, rlim) - ang[ax]);
      end
      err = target - (rates[ax] <<< GAIN_FRAC);
      acc = integ[ax] + (longint'(gains.integ_gain) * err) / (longint'(1) <<< INC_SHIFT);
      acc = clip(acc, -ilim, ilim);
      if (s.throttle < gains.throttle_min) acc = 0;
      integ[ax] = acc;
      total = (longint'(gains.inner_gain) * err + (acc <<< INC_SHIFT))
              / (longint'(1) <<< OUT_SHIFT);
      total = clip(total, -32768, 32767);
      if (ax == AXIS_ROLL) d.roll = total[SIG_W-1:0];
      else if (ax == AXIS_PITCH) d.pitch = total[SIG_W-1:0];
      else d.yaw = total[SIG_W-1:0];
    end
    d.alt = a;
    return d;
  endfunction

  task automatic report_bad(input string what, input longint got, input longint want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drives_t want;
    if (!rst_ni) begin
      gains = '{outer_gain: 12'd512, inner_gain: 12'd256, integ_gain: 12'd307,
                integ_limit: 12'd500, throttle_min: 12'd100, yaw_scale: 12'd1024,
                ref_limit: 11'd50};
      integ = '{0, 0, 0};
      expected_drives.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_drives.size() == 0) begin
          report_bad("result beat with none outstanding, roll", drive_roll_i, 0);
        end else begin
          want = expected_drives.pop_front();
          if (drive_roll_i !== want.roll) report_bad("drive_roll", drive_roll_i, want.roll);
          if (drive_pitch_i !== want.pitch) report_bad("drive_pitch", drive_pitch_i, want.pitch);
          if (drive_yaw_i !== want.yaw) report_bad("drive_yaw", drive_yaw_i, want.yaw);
          if (drive_alt_i !== want.alt) report_bad("drive_alt", drive_alt_i, want.alt);
        end
      end
      if (in_valid_i && !in_stall_i) expected_drives.push_back(predict_drives(sample_i, alt_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_OUTER_GAIN:   gains.outer_gain   = cfg_data_i;
          REG_INNER_GAIN:   gains.inner_gain   = cfg_data_i;
          REG_INTEG_GAIN:   gains.integ_gain   = cfg_data_i;
          REG_INTEG_LIMIT:  gains.integ_limit  = cfg_data_i;
          REG_THROTTLE_MIN: gains.throttle_min = cfg_data_i;
          REG_YAW_SCALE:    gains.yaw_scale    = cfg_data_i;
          REG_REF_LIMIT:    gains.ref_limit    = cfg_data_i[RLIM_W-1:0];
          default: ;
        endcase
      end
      pending_o <= expected_drives.size();
    end
  end

endmodule

FILE: tb/tb_cascaded_attitude_pi_controller_top.sv
module tb_cascaded_attitude_pi_controller_top;
  import capc_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int TAIL_CYCLES = 40;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  sample_t                 tick      = '0;
  logic [ALT_W-1:0]        alt       = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SIG_W-1:0] drive_roll;
  logic signed [SIG_W-1:0] drive_pitch;
  logic signed [SIG_W-1:0] drive_yaw;
  logic [ALT_W-1:0]        drive_alt;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [GAIN_W-1:0]       cfg_data  = '0;
  int unsigned             fail_cnt;
  int unsigned             pending;

  stall_mode_e stall_mode  = STALL_NONE;
  int          stall_left  = 0;
  int          burst_left  = 0;
  int          drift[3]    = '{0, 0, 0};
  int          thr_floor   = 100;
  int          ref_lim_now = 50;

  cascaded_attitude_pi_controller_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .ref_roll_i    (tick.ref_roll),
    .ref_pitch_i   (tick.ref_pitch),
    .ref_yaw_i     (tick.ref_yaw),
    .ref_alt_i     (alt),
    .angle_roll_i  (tick.angle_roll),
    .angle_pitch_i (tick.angle_pitch),
    .rate_roll_i   (tick.rate_roll),
    .rate_pitch_i  (tick.rate_pitch),
    .rate_yaw_i    (tick.rate_yaw),
    .throttle_i    (tick.throttle),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .drive_roll_o  (drive_roll),
    .drive_pitch_o (drive_pitch),
    .drive_yaw_o   (drive_yaw),
    .drive_alt_o   (drive_alt),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  attitude_drive_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_i      (tick),
    .alt_i         (alt),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .drive_roll_i  (drive_roll),
    .drive_pitch_i (drive_pitch),
    .drive_yaw_i   (drive_yaw),
    .drive_alt_i   (drive_alt),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver back-pressure in stretches of differing density
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default:     out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic sample_t mk(input int rr, input int rp, input int ry, input int ar,
                                 input int ap, input int wr, input int wp, input int wy,
                                 input int thr);
    sample_t s;
    s.ref_roll    = SIG_W'(rr);
    s.ref_pitch   = SIG_W'(rp);
    s.ref_yaw     = SIG_W'(ry);
    s.angle_roll  = SIG_W'(ar);
    s.angle_pitch = SIG_W'(ap);
    s.rate_roll   = SIG_W'(wr);
    s.rate_pitch  = SIG_W'(wp);
    s.rate_yaw    = SIG_W'(wy);
    s.throttle    = THR_W'(thr);
    return s;
  endfunction

  function automatic int near_zero(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_tick(input sample_t s, input logic [ALT_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    tick     <= s;
    alt      <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly flight-like ticks with slowly drifting rate error, some pure noise
  task automatic send_random(input int count);
    sample_t s;
    int      span;
    int      a;
    repeat (count) begin
      for (a = 0; a < 3; a++) begin
        drift[a] += int'($urandom_range(0, 100)) - 50;
        if ($urandom_range(0, 63) == 0) drift[a] = -drift[a];
        if (drift[a] > 3000) drift[a] = 3000;
        if (drift[a] < -3000) drift[a] = -3000;
      end
      if ($urandom_range(0, 9) < 2) begin
        s.ref_roll    = SIG_W'($urandom);
        s.ref_pitch   = SIG_W'($urandom);
        s.ref_yaw     = SIG_W'($urandom);
        s.angle_roll  = SIG_W'($urandom);
        s.angle_pitch = SIG_W'($urandom);
        s.rate_roll   = SIG_W'($urandom);
        s.rate_pitch  = SIG_W'($urandom);
        s.rate_yaw    = SIG_W'($urandom);
        s.throttle    = THR_W'($urandom_range(0, 4095));
      end else begin
        span = ref_lim_now * 16 + 64;
        if (span > 32767) span = 32767;
        s.ref_roll    = SIG_W'(near_zero(span));
        s.ref_pitch   = SIG_W'(near_zero(span));
        s.ref_yaw     = SIG_W'(near_zero(400));
        s.angle_roll  = SIG_W'(near_zero(600));
        s.angle_pitch = SIG_W'(near_zero(600));
        s.rate_roll   = SIG_W'(near_zero(200) + drift[0]);
        s.rate_pitch  = SIG_W'(near_zero(200) + drift[1]);
        s.rate_yaw    = SIG_W'(near_zero(200) + drift[2]);
        if (thr_floor > 0 && $urandom_range(0, 7) == 0) begin
          s.throttle = THR_W'($urandom_range(0, thr_floor - 1));
        end else begin
          s.throttle = THR_W'($urandom_range(thr_floor, 4095));
        end
      end
      send_tick(s, ALT_W'($urandom_range(0, 4095)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input int og, input int ig, input int kg, input int il,
                             input int tm, input int ys, input int rl);
    write_reg(REG_OUTER_GAIN, GAIN_W'(og));
    write_reg(REG_INNER_GAIN, GAIN_W'(ig));
    write_reg(REG_INTEG_GAIN, GAIN_W'(kg));
    write_reg(REG_INTEG_LIMIT, GAIN_W'(il));
    write_reg(REG_THROTTLE_MIN, GAIN_W'(tm));
    write_reg(REG_YAW_SCALE, GAIN_W'(ys));
    write_reg(REG_REF_LIMIT, GAIN_W'(rl));
    cfg_valid   <= 1'b0;
    thr_floor   = tm & 12'hFFF;
    ref_lim_now = rl & 11'h7FF;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: field extremes
    send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_tick(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 4095), 4095);
    send_tick(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 4095), 0);
    send_tick(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 2048), 12'hAAA);
    send_tick(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 2048), 12'h555);
    // reference at, past and inside its clamp
    send_tick(mk(800, -800, 0, 0, 0, 0, 0, 0, 500), 1);
    send_tick(mk(801, -801, 0, 0, 0, 0, 0, 0, 500), 2);
    send_tick(mk(799, -799, 0, 0, 0, 0, 0, 0, 500), 3);
    // wind up to the integrator clamp, then cut throttle at and below the floor
    repeat (6) send_tick(mk(800, -800, 200, 0, 0, 0, 0, 0, 1000), 100);
    send_tick(mk(800, -800, 200, 0, 0, 0, 0, 0, 100), 100);
    send_tick(mk(800, -800, 200, 0, 0, 0, 0, 0, 99), 99);
    repeat (3) send_tick(mk(-800, 800, -200, 0, 0, 0, 0, 0, 4095), 7);
    send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 100), 0);
    send_tick(mk(16, -16, 32767, 0, 0, -1, 1, -32768, 3000), 0);
    send_random(350);

    drain();
    write_reg(REG_UNUSED, 12'h5A5);
    load_config(4095, 4095, 4095, 4095, 4095, 4095, 12'hFFF);
    send_random(250);

    drain();
    load_config(0, 0, 0, 0, 0, 0, 0);
    send_random(200);

    // integrator limit just past the 18-bit range
    drain();
    load_config(512, 256, 4095, 512, 0, 1024, 50);
    send_random(200);

    repeat (5) begin
      drain();
      load_config($urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 400), $urandom_range(0, 4095),
                  $urandom_range(0, 2047));
      send_random(170);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: cascaded_attitude_pi_controller_top.f
src/capc_pkg.sv
src/capc_datapath.sv
src/cascaded_attitude_pi_controller_top.sv
tb/attitude_drive_checker.sv
tb/tb_cascaded_attitude_pi_controller_top.sv
